[rtl/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants of the image histogram statistics core.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

    localparam int NUM_BINS    = 128;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int COUNT_WIDTH = 24;
    localparam int TOTAL_W     = 25;
    localparam int DIV_W       = 128;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int SQRT_STEPS  = 32;
    localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_PIXEL  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_READ   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        REG_RANGE_MIN = 2'd0,
        REG_BIN_SCALE = 2'd1,
        REG_BIN_WIDTH = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_MEAN = 2'd0,
        DIV_SQ   = 2'd1,
        DIV_VAR  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic             load;
        logic             clear;
        logic             px_abs;
        logic             px_mul;
        logic             px_bin;
        logic             px_acc;
        logic             px_inc;
        logic             rd_bin;
        logic             emit_read;
        logic             scan_rd;
        logic             scan_first;
        logic             scan_cmp;
        logic [BIN_W-1:0] scan_addr;
        logic             sq_step;
        logic [1:0]       sq_idx;
        logic             div_start;
        div_sel_t         div_sel;
        logic             take_mean;
        logic             take_sq;
        logic             take_var;
        logic             sqrt_start;
        logic             take_std;
        logic             mode_mul;
        logic             emit_fin;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/hsc_div.sv]
// ----------------------------------------------------------------------------
// hsc_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [hsc_pkg::DIV_W-1:0]   dividend,
    input  wire logic [hsc_pkg::TOTAL_W-1:0] divisor,
    output logic      [hsc_pkg::DIV_W-1:0]   quotient,
    output logic                             done
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [hsc_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [hsc_pkg::DIV_W-1:0]       work_reg;
    logic [hsc_pkg::TOTAL_W-1:0]     rem_reg;
    logic [hsc_pkg::TOTAL_W-1:0]     dsr_reg;
    logic [hsc_pkg::TOTAL_W:0]       shifted;
    logic [hsc_pkg::TOTAL_W:0]       diff;
    logic                            take;

    always_comb
    begin
        shifted = {rem_reg, work_reg[hsc_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        take    = (shifted >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == hsc_pkg::DIV_CNT_W'(hsc_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[hsc_pkg::DIV_W-2:0], take};
            rem_reg  <= take ? diff[hsc_pkg::TOTAL_W-1:0] : shifted[hsc_pkg::TOTAL_W-1:0];
        end
    end

    assign quotient = work_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

[rtl/hsc_sqrt.sv]
// ----------------------------------------------------------------------------
// hsc_sqrt
// Digit-by-digit integer square root of a 64-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root,
    output logic             done
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [hsc_pkg::SQRT_CNT_W-1:0]   cnt_reg;
    logic [63:0]                      val_reg;
    logic [33:0]                      rem_reg;
    logic [31:0]                      root_reg;
    logic [35:0]                      rem_sh;
    logic [35:0]                      trial;
    logic [35:0]                      rem_sub;
    logic                             take;

    always_comb
    begin
        rem_sh  = {rem_reg, val_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        rem_sub = rem_sh - trial;
        take    = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == hsc_pkg::SQRT_CNT_W'(hsc_pkg::SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[61:0], 2'b00};
            rem_reg  <= take ? rem_sub[33:0] : rem_sh[33:0];
            root_reg <= {root_reg[30:0], take};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[rtl/hsc_dp.sv]
// ----------------------------------------------------------------------------
// hsc_dp
// Datapath: configuration, bin store, accumulators, statistics and results.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire hsc_pkg::dp_cmd_t                cmd,
    output hsc_pkg::dp_status_t                  status,
    input  wire logic                            cfg_write,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [31:0]                     cfg_data,
    input  wire logic [31:0]                     pixel,
    input  wire logic [6:0]                      bin_index,
    output logic                                 done,
    output logic      [31:0]                     mean_value,
    output logic      [31:0]                     std_dev,
    output logic      [31:0]                     mode_value,
    output logic      [hsc_pkg::COUNT_WIDTH-1:0] peak_count,
    output logic      [hsc_pkg::COUNT_WIDTH-1:0] bin_count,
    output logic                                 overflow
);

    localparam int MODE_W = hsc_pkg::BIN_W + 32;
    localparam int MSUM_W = MODE_W + 2;

    logic [31:0]                       range_min_reg;
    logic [31:0]                       bin_scale_reg;
    logic [31:0]                       bin_width_reg;

    logic [hsc_pkg::COUNT_WIDTH-1:0]   mem [hsc_pkg::NUM_BINS];
    logic [hsc_pkg::NUM_BINS-1:0]      valid_reg;
    logic [hsc_pkg::COUNT_WIDTH-1:0]   rdata_reg;
    logic                              rvalid_reg;
    logic [hsc_pkg::BIN_W-1:0]         addr_q_reg;
    logic [hsc_pkg::BIN_W-1:0]         rd_addr;
    logic [hsc_pkg::COUNT_WIDTH-1:0]   rcount;
    logic [hsc_pkg::COUNT_WIDTH-1:0]   inc_count;

    logic [31:0]                       pixel_reg;
    logic [6:0]                        idx_reg;
    logic                              idx_ok;

    logic [hsc_pkg::TOTAL_W-1:0]       total_reg;
    logic [63:0]                       sum_reg;
    logic [63:0]                       ssum_reg;
    logic                              sat_reg;

    logic [32:0]                       dmag_reg;
    logic                              dneg_reg;
    logic [31:0]                       pabs_reg;
    logic                              full_reg;
    logic [48:0]                       pa_reg;
    logic [48:0]                       pb_reg;
    logic [63:0]                       sq_reg;
    logic [hsc_pkg::BIN_W-1:0]         bin_reg;

    logic [32:0]                       diff33;
    logic [64:0]                       bprod;
    logic [32:0]                       ip;
    logic [31:0]                       fr;
    logic [33:0]                       jsum;
    logic [hsc_pkg::BIN_W-1:0]         bin_next;
    logic [64:0]                       ssum_add;

    logic [hsc_pkg::COUNT_WIDTH-1:0]   peak_reg;
    logic [hsc_pkg::BIN_W-1:0]         best_reg;
    logic [63:0]                       sum_mag;
    logic [31:0]                       mul_a;
    logic [31:0]                       mul_b;
    logic [63:0]                       mul_p;
    logic [127:0]                      mul_term;
    logic [127:0]                      acc_reg;

    logic [hsc_pkg::DIV_W-1:0]         div_dvd;
    logic [hsc_pkg::TOTAL_W-1:0]       div_dsr;
    logic [hsc_pkg::DIV_W-1:0]         div_q;
    logic                              div_done;
    logic [31:0]                       sqrt_root;
    logic                              sqrt_done;

    logic [31:0]                       mean_reg;
    logic                              zero_reg;
    logic [63:0]                       diff_reg;
    logic [63:0]                       var_reg;
    logic [31:0]                       std_reg;
    logic [MODE_W-1:0]                 mprod_reg;
    logic signed [MSUM_W-1:0]          msum;
    logic [31:0]                       mode_sat;

    logic                              done_reg;
    logic [31:0]                       mean_out_reg;
    logic [31:0]                       std_out_reg;
    logic [31:0]                       mode_out_reg;
    logic [hsc_pkg::COUNT_WIDTH-1:0]   peak_out_reg;
    logic [hsc_pkg::COUNT_WIDTH-1:0]   bin_out_reg;
    logic                              ovf_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= 32'd0;
            bin_scale_reg <= 32'd65536;
            bin_width_reg <= 32'd65536;
        end
        else if (cfg_write)
        begin
            case (hsc_pkg::cfg_reg_t'(cfg_index))
                hsc_pkg::REG_RANGE_MIN: range_min_reg <= cfg_data;
                hsc_pkg::REG_BIN_SCALE: bin_scale_reg <= cfg_data;
                hsc_pkg::REG_BIN_WIDTH: bin_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (cmd.scan_rd)
            rd_addr = cmd.scan_addr;
        else if (cmd.rd_bin)
            rd_addr = hsc_pkg::BIN_W'(idx_reg);
        else
            rd_addr = bin_reg;
        rcount    = rvalid_reg ? rdata_reg : '0;
        inc_count = (rcount == '1) ? rcount : rcount + 1'b1;
        idx_ok    = (int'(idx_reg) < hsc_pkg::NUM_BINS);
    end

    always_ff @(posedge clk)
    begin
        rdata_reg  <= mem[rd_addr];
        addr_q_reg <= rd_addr;
        if (cmd.px_inc && !full_reg)
            mem[addr_q_reg] <= inc_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            total_reg  <= '0;
            sum_reg    <= '0;
            ssum_reg   <= '0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[rd_addr];
            if (cmd.clear)
            begin
                valid_reg <= '0;
                total_reg <= '0;
                sum_reg   <= '0;
                ssum_reg  <= '0;
                sat_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.px_inc && !full_reg)
                    valid_reg[addr_q_reg] <= 1'b1;
                if (cmd.px_acc && !full_reg)
                begin
                    total_reg <= total_reg + 1'b1;
                    sum_reg   <= sum_reg + {{32{pixel_reg[31]}}, pixel_reg};
                    if (ssum_add[64])
                    begin
                        ssum_reg <= '1;
                        sat_reg  <= 1'b1;
                    end
                    else
                    begin
                        ssum_reg <= ssum_add[63:0];
                    end
                end
            end
        end
    end

    always_comb
    begin
        diff33   = {pixel_reg[31], pixel_reg} - {range_min_reg[31], range_min_reg};
        bprod    = {pa_reg, 16'b0} + {16'b0, pb_reg};
        ip       = bprod[64:32];
        fr       = bprod[31:0];
        jsum     = {1'b0, ip} + {33'b0, fr[31]};
        ssum_add = {1'b0, ssum_reg} + {1'b0, sq_reg};
        if (!dneg_reg)
        begin
            if (jsum >= 34'(hsc_pkg::NUM_BINS - 1))
                bin_next = hsc_pkg::BIN_W'(hsc_pkg::NUM_BINS - 1);
            else
                bin_next = hsc_pkg::BIN_W'(jsum) + 1'b1;
        end
        else if ((ip == '0) && (fr <= 32'h8000_0000))
        begin
            bin_next = hsc_pkg::BIN_W'(1);
        end
        else
        begin
            bin_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pixel_reg <= pixel;
            idx_reg   <= bin_index;
        end
        if (cmd.px_abs)
        begin
            dneg_reg <= diff33[32];
            dmag_reg <= diff33[32] ? (33'd0 - diff33) : diff33;
            pabs_reg <= pixel_reg[31] ? (32'd0 - pixel_reg) : pixel_reg;
            full_reg <= (total_reg == '1);
        end
        if (cmd.px_mul)
        begin
            pa_reg <= dmag_reg * bin_scale_reg[31:16];
            pb_reg <= dmag_reg * bin_scale_reg[15:0];
            sq_reg <= pabs_reg * pabs_reg;
        end
        if (cmd.px_bin)
            bin_reg <= bin_next;
    end

    always_comb
    begin
        sum_mag = sum_reg[63] ? (64'd0 - sum_reg) : sum_reg;
        case (cmd.sq_idx)
            2'd0:
            begin
                mul_a = sum_mag[31:0];
                mul_b = sum_mag[31:0];
            end
            2'd1:
            begin
                mul_a = sum_mag[31:0];
                mul_b = sum_mag[63:32];
            end
            2'd2:
            begin
                mul_a = sum_mag[63:32];
                mul_b = sum_mag[31:0];
            end
            default:
            begin
                mul_a = sum_mag[63:32];
                mul_b = sum_mag[63:32];
            end
        endcase
        mul_p = mul_a * mul_b;
        case (cmd.sq_idx)
            2'd0:    mul_term = {64'b0, mul_p};
            2'd1:    mul_term = {32'b0, mul_p, 32'b0};
            2'd2:    mul_term = {32'b0, mul_p, 32'b0};
            default: mul_term = {mul_p, 64'b0};
        endcase
        case (cmd.div_sel)
            hsc_pkg::DIV_MEAN:
            begin
                div_dvd = {64'b0, sum_mag};
                div_dsr = total_reg;
            end
            hsc_pkg::DIV_SQ:
            begin
                div_dvd = acc_reg;
                div_dsr = total_reg;
            end
            default:
            begin
                div_dvd = {64'b0, diff_reg};
                div_dsr = total_reg - 1'b1;
            end
        endcase
    end

    hsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (div_q),
        .done     (div_done)
    );

    hsc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (var_reg),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_first)
        begin
            peak_reg <= '0;
            best_reg <= '0;
        end
        else if (cmd.scan_cmp && (rcount >= peak_reg))
        begin
            peak_reg <= rcount;
            best_reg <= addr_q_reg;
        end
        if (cmd.sq_step)
            acc_reg <= ((cmd.sq_idx == 2'd0) ? 128'd0 : acc_reg) + mul_term;
        if (cmd.take_mean)
        begin
            if (total_reg == '0)
                mean_reg <= '0;
            else
                mean_reg <= sum_reg[63] ? (32'd0 - div_q[31:0]) : div_q[31:0];
        end
        if (cmd.take_sq)
        begin
            zero_reg <= (div_q[127:64] != '0) || (div_q[63:0] >= ssum_reg);
            diff_reg <= ssum_reg - div_q[63:0];
        end
        if (cmd.take_var)
            var_reg <= div_q[63:0];
        if (cmd.take_std)
            std_reg <= ((total_reg < hsc_pkg::TOTAL_W'(2)) || zero_reg) ? '0 : sqrt_root;
        if (cmd.mode_mul)
            mprod_reg <= best_reg * bin_width_reg;
    end

    always_comb
    begin
        msum = signed'({{(MSUM_W-32){range_min_reg[31]}}, range_min_reg})
             + signed'({2'b00, mprod_reg});
        if (msum > signed'(MSUM_W'(32'h7FFF_FFFF)))
            mode_sat = 32'h7FFF_FFFF;
        else if (msum < signed'({{(MSUM_W-32){1'b1}}, 32'h8000_0000}))
            mode_sat = 32'h8000_0000;
        else
            mode_sat = msum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit_read || cmd.emit_fin;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_read)
        begin
            mean_out_reg <= '0;
            std_out_reg  <= '0;
            mode_out_reg <= '0;
            peak_out_reg <= '0;
            bin_out_reg  <= idx_ok ? rcount : '0;
            ovf_out_reg  <= sat_reg;
        end
        else if (cmd.emit_fin)
        begin
            mean_out_reg <= mean_reg;
            std_out_reg  <= std_reg;
            mode_out_reg <= mode_sat;
            peak_out_reg <= peak_reg;
            bin_out_reg  <= '0;
            ovf_out_reg  <= sat_reg;
        end
    end

    assign done       = done_reg;
    assign mean_value = mean_out_reg;
    assign std_dev    = std_out_reg;
    assign mode_value = mode_out_reg;
    assign peak_count = peak_out_reg;
    assign bin_count  = bin_out_reg;
    assign overflow   = ovf_out_reg;

endmodule

`default_nettype wire

[rtl/hsc_ctrl.sv]
// ----------------------------------------------------------------------------
// hsc_ctrl
// Command sequencer driving the datapath through pixel, read and finish flows.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          command,
    output logic                     busy,
    output hsc_pkg::dp_cmd_t         cmd,
    input  wire hsc_pkg::dp_status_t status
);

    localparam int CNT_W = hsc_pkg::BIN_W + 1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_PIX1,
        S_PIX2,
        S_PIX3,
        S_PIX4,
        S_PIX5,
        S_RD1,
        S_RD2,
        S_SCAN,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_SQR,
        S_SQ_GO,
        S_SQ_WAIT,
        S_VAR_GO,
        S_VAR_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_MODE,
        S_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.div_sel = hsc_pkg::DIV_MEAN;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    case (hsc_pkg::command_t'(command))
                        hsc_pkg::CMD_START:  state_next = S_CLEAR;
                        hsc_pkg::CMD_PIXEL:  state_next = S_PIX1;
                        hsc_pkg::CMD_FINISH: state_next = S_SCAN;
                        hsc_pkg::CMD_READ:   state_next = S_RD1;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
            end
            S_PIX1:
            begin
                cmd.px_abs = 1'b1;
                state_next = S_PIX2;
            end
            S_PIX2:
            begin
                cmd.px_mul = 1'b1;
                state_next = S_PIX3;
            end
            S_PIX3:
            begin
                cmd.px_bin = 1'b1;
                state_next = S_PIX4;
            end
            S_PIX4:
            begin
                cmd.px_acc = 1'b1;
                state_next = S_PIX5;
            end
            S_PIX5:
            begin
                cmd.px_inc = 1'b1;
                state_next = S_IDLE;
            end
            S_RD1:
            begin
                cmd.rd_bin = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.emit_read = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_rd    = (cnt_reg != CNT_W'(hsc_pkg::NUM_BINS));
                cmd.scan_addr  = cnt_reg[hsc_pkg::BIN_W-1:0];
                cmd.scan_first = (cnt_reg == '0);
                cmd.scan_cmp   = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(hsc_pkg::NUM_BINS))
                    state_next = S_MEAN_GO;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = hsc_pkg::DIV_MEAN;
                state_next    = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.take_mean = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_SQR;
                end
            end
            S_SQR:
            begin
                cmd.sq_step = 1'b1;
                cmd.sq_idx  = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(3))
                    state_next = S_SQ_GO;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SQ_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = hsc_pkg::DIV_SQ;
                state_next    = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.take_sq = 1'b1;
                    state_next  = S_VAR_GO;
                end
            end
            S_VAR_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = hsc_pkg::DIV_VAR;
                state_next    = S_VAR_WAIT;
            end
            S_VAR_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.take_var = 1'b1;
                    state_next   = S_SQRT_GO;
                end
            end
            S_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (status.sqrt_done)
                begin
                    cmd.take_std = 1'b1;
                    state_next   = S_MODE;
                end
            end
            S_MODE:
            begin
                cmd.mode_mul = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_fin = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[rtl/image_histogram_statistics_core.sv]
// ----------------------------------------------------------------------------
// image_histogram_statistics_core
// Intensity histogram of Q16.16 pixels with mean, deviation and mode.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the command is complete. Start/clear and pixel commands raise no done;
// a bin read and finish end with done high for a single cycle with the result.
// Finish is a bin scan through the count memory, then three quotients from
// one bit-serial divider at one bit per cycle and a bit-serial square root.
// Bin counts clear at start through per-bin valid flags, so there is no
// clearing pass after reset. The result cannot be held off: sample it in
// the cycle that done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module image_histogram_statistics_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          command,
    input  wire logic [31:0]                         pixel,
    input  wire logic [6:0]                          bin_index,
    input  wire logic                                cfg_write,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [31:0]                         cfg_data,
    output logic                                     done,
    output logic      [31:0]                         mean_value,
    output logic      [31:0]                         std_dev,
    output logic      [31:0]                         mode_value,
    output logic      [hsc_pkg::COUNT_WIDTH-1:0]     peak_count,
    output logic      [hsc_pkg::COUNT_WIDTH-1:0]     bin_count,
    output logic                                     overflow
);

    hsc_pkg::dp_cmd_t    cmd;
    hsc_pkg::dp_status_t status;

    hsc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .cmd     (cmd),
        .status  (status)
    );

    hsc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel),
        .bin_index  (bin_index),
        .done       (done),
        .mean_value (mean_value),
        .std_dev    (std_dev),
        .mode_value (mode_value),
        .peak_count (peak_count),
        .bin_count  (bin_count),
        .overflow   (overflow)
    );

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a command in progress");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer still busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
`endif

endmodule

`default_nettype wire
